### rtl/core/pfba_pkg.sv
`default_nettype none
package pfba_pkg;

  localparam int unsigned MAX_FRAMES   = 8;
  localparam int unsigned OFFSET_BITS  = 32;
  localparam int unsigned STREAK_LIMIT = 3;

  localparam logic [31:0] OUT_MASK = (OFFSET_BITS >= 32) ? 32'hFFFF_FFFF :
                                     32'((64'd1 << OFFSET_BITS) - 64'd1);

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 152;

  typedef enum logic [1:0] {
    ST_PLACED   = 2'd0,
    ST_FALLBACK = 2'd1,
    ST_REJECTED = 2'd2,
    ST_FRAME    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_POOL_ENABLED = 2'd0,
    CFG_BUFFER_BYTES = 2'd1,
    CFG_FRAME_COUNT  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] req_bytes;
    logic [4:0]  align_log2;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] offset;
    logic [32:0] fallback_bytes;
    logic [2:0]  slot;
    logic [31:0] used_after;
    logic [31:0] fb_count;
    logic [15:0] fallback_streak;
    logic        degrade_warning;
  } res_t;

  // Remainder of a small slot number by the slot count; the value never
  // exceeds eight, so eight conditional subtractions always suffice.
  function automatic logic [3:0] slot_mod(input logic [3:0] v, input logic [3:0] n);
    logic [3:0] r;
    r = v;
    for (int i = 0; i < 8; i++) begin
      if (r >= n) begin
        r = r - n;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/core/pfba_in_reg.sv
`default_nettype none
module pfba_in_reg
  import pfba_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic                 in_tuser,
  input  wire logic                 advance,
  output logic                      vld,
  output req_t                      req
);

  logic vld_r;
  logic vld_nxt;
  req_t req_r;

  assign in_tready = !vld_r || advance;

  always_comb begin
    vld_nxt = vld_r;
    if (in_tvalid && in_tready) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r.req_type   <= in_tuser;
      req_r.req_bytes  <= in_tdata[31:0];
      req_r.align_log2 <= in_tdata[36:32];
    end
  end

  assign vld = vld_r;
  assign req = req_r;

endmodule
`default_nettype wire

### rtl/core/pfba_core.sv
`default_nettype none
module pfba_core
  import pfba_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        fire,
  input  req_t             req,
  output res_t             res
);

  logic        pool_en_r;
  logic [31:0] buf_bytes_r;
  logic [3:0]  frame_cnt_r;

  logic [31:0] fill_r,     fill_nxt;
  logic [2:0]  slot_r,     slot_nxt;
  logic [31:0] total_r,    total_nxt;
  logic [15:0] frame_fb_r, frame_fb_nxt;
  logic [15:0] streak_r,   streak_nxt;
  logic        warned_r,   warned_nxt;

  logic [3:0]  slots_used;
  logic [32:0] align_m1;
  logic [32:0] aligned;
  logic [33:0] end_pos;
  logic [32:0] fb_size;
  logic        fits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_en_r   <= 1'b0;
      buf_bytes_r <= 32'd1048576;
      frame_cnt_r <= 4'd3;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_POOL_ENABLED: pool_en_r   <= cfg_wdata[0];
        CFG_BUFFER_BYTES: buf_bytes_r <= cfg_wdata;
        CFG_FRAME_COUNT:  frame_cnt_r <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (frame_cnt_r == 4'd0) begin
      slots_used = 4'd1;
    end else if (frame_cnt_r > 4'(MAX_FRAMES)) begin
      slots_used = 4'(MAX_FRAMES);
    end else begin
      slots_used = frame_cnt_r;
    end
  end

  assign align_m1 = (33'd1 << req.align_log2) - 33'd1;
  assign aligned  = ({1'b0, fill_r} + align_m1) & ~align_m1;
  assign end_pos  = {1'b0, aligned} + {2'b00, req.req_bytes};
  assign fits     = end_pos <= {2'b00, buf_bytes_r};
  assign fb_size  = ({1'b0, req.req_bytes} + align_m1) & ~align_m1;

  always_comb begin
    fill_nxt     = fill_r;
    slot_nxt     = slot_r;
    total_nxt    = total_r;
    frame_fb_nxt = frame_fb_r;
    streak_nxt   = streak_r;
    warned_nxt   = warned_r;

    res.status          = ST_REJECTED;
    res.offset          = 32'd0;
    res.fallback_bytes  = 33'd0;
    res.degrade_warning = 1'b0;

    priority if (!pool_en_r) begin
      res.status = ST_REJECTED;
    end else if (req.req_type) begin
      slot_nxt = 3'(slot_mod(4'({1'b0, slot_r} + 4'd1), slots_used));
      fill_nxt = 32'd0;
      if (frame_fb_r != 16'd0) begin
        if (streak_r != 16'hFFFF) begin
          streak_nxt = streak_r + 16'd1;
        end
        if (streak_nxt >= 16'(STREAK_LIMIT) && !warned_r) begin
          warned_nxt          = 1'b1;
          res.degrade_warning = 1'b1;
        end
      end else begin
        streak_nxt = 16'd0;
        warned_nxt = 1'b0;
      end
      frame_fb_nxt = 16'd0;
      res.status   = ST_FRAME;
    end else if (req.req_bytes == 32'd0) begin
      res.status = ST_REJECTED;
    end else if (fits) begin
      res.offset = aligned[31:0] & OUT_MASK;
      fill_nxt   = end_pos[31:0];
      res.status = ST_PLACED;
    end else begin
      res.fallback_bytes = fb_size;
      if (total_r != 32'hFFFF_FFFF) begin
        total_nxt = total_r + 32'd1;
      end
      if (frame_fb_r != 16'hFFFF) begin
        frame_fb_nxt = frame_fb_r + 16'd1;
      end
      res.status = ST_FALLBACK;
    end

    res.slot            = slot_nxt;
    res.used_after      = fill_nxt & OUT_MASK;
    res.fb_count        = total_nxt;
    res.fallback_streak = streak_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= 32'd0;
      slot_r     <= 3'd0;
      total_r    <= 32'd0;
      frame_fb_r <= 16'd0;
      streak_r   <= 16'd0;
      warned_r   <= 1'b0;
    end else if (fire) begin
      fill_r     <= fill_nxt;
      slot_r     <= slot_nxt;
      total_r    <= total_nxt;
      frame_fb_r <= frame_fb_nxt;
      streak_r   <= streak_nxt;
      warned_r   <= warned_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/core/pfba_out_reg.sv
`default_nettype none
module pfba_out_reg
  import pfba_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load,
  input  res_t                       res,
  output logic                       free,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [1:0]                 out_tuser
);

  logic vld_r;
  logic vld_nxt;
  res_t res_r;

  assign free = !vld_r || out_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tuser  = res_r.status;
  assign out_tdata  = {3'b000,
                       res_r.degrade_warning,
                       res_r.fallback_streak,
                       res_r.fb_count,
                       res_r.used_after,
                       res_r.slot,
                       res_r.fallback_bytes,
                       res_r.offset};

endmodule
`default_nettype wire

### rtl/core/per_frame_bump_allocator.sv
`default_nettype none
// Linear bump allocator over a ring of frame slots. Each request either
// allocates bytes at an aligned offset in the current slot (or reports that a
// fallback of the aligned size is needed), or begins a new frame, which moves
// to the next slot and clears its fill level. With the pool disabled every
// request is rejected, as is an allocation of zero bytes. One request is taken
// per cycle unless the result side stalls; each goes through the input
// register, the allocation arithmetic and counter updates, then the result
// register; result back-pressure stalls the input only once both are full.
module per_frame_bump_allocator
  import pfba_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_addr,
  input  wire logic [31:0]           cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // req_bytes[31:0], align_log2[36:32], zero padding above
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // req_type
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // offset[31:0], fallback_bytes[64:32], slot[67:65], used_after[99:68],
  // total fallback count[131:100], fallback_streak[147:132],
  // degrade_warning[148], zero padding above
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // status
  output logic [1:0]                 out_tuser
);

  logic  in_vld;
  logic  out_free;
  logic  fire;
  req_t  req;
  res_t  res;

  assign fire = in_vld && out_free;

  pfba_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .advance   (fire),
    .vld       (in_vld),
    .req       (req)
  );

  pfba_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .req       (req),
    .res       (res)
  );

  pfba_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
